>>> rtl/kbr_pkg.sv
package kbr_pkg;

  // Fixed field widths.
  localparam int KEY_W  = 8;
  localparam int CODE_W = 16;
  localparam int MIDX_W = 9;

  // Report layout.
  localparam int MOD_KEYS    = 8;
  localparam int INPUT_SLOTS = 6;
  localparam int IDX_W       = 3;

  // Parameter defaults.
  localparam int KEY_SLOTS_DEF   = 6;
  localparam int MAP_ENTRIES_DEF = 256;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOD,
    ST_KEY_RD,
    ST_KEY_CHK,
    ST_REL_RD,
    ST_REL_CHK,
    ST_FIN
  } state_t;

  // Source of the event under test in the datapath.
  typedef enum logic [1:0] {
    SRC_MOD,
    SRC_KEY,
    SRC_REL
  } src_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic map_wr;
    logic idx_clr;
    logic idx_inc;
    logic rd_key;
    logic rd_rel;
    logic step;
    logic finish;
    src_t src;
  } ctl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic mod_last;
    logic key_end;
    logic rel_end;
    logic adv_ok;
    logic fin_ok;
  } ctl_stat_t;

endpackage

>>> rtl/kbr_ram.sv
module kbr_ram
  import kbr_pkg::*;
#(
  parameter int WIDTH = CODE_W,
  parameter int DEPTH = MAP_ENTRIES_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Single write port, registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/kbr_ctrl.sv
module kbr_ctrl
  import kbr_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  logic      mode,
  output logic      in_stall,
  input  ctl_stat_t stat,
  output ctl_cmd_t  cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid && !mode) begin
          state_next = ST_MOD;
        end
      end
      ST_MOD: begin
        if (stat.adv_ok && stat.mod_last) begin
          state_next = ST_KEY_RD;
        end
      end
      ST_KEY_RD: begin
        state_next = stat.key_end ? ST_REL_RD : ST_KEY_CHK;
      end
      ST_KEY_CHK: begin
        if (stat.adv_ok) begin
          state_next = ST_KEY_RD;
        end
      end
      ST_REL_RD: begin
        state_next = stat.rel_end ? ST_FIN : ST_REL_CHK;
      end
      ST_REL_CHK: begin
        if (stat.adv_ok) begin
          state_next = ST_REL_RD;
        end
      end
      ST_FIN: begin
        if (stat.fin_ok) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    cmd      = '0;
    cmd.src  = SRC_MOD;
    in_stall = (state != ST_IDLE);
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load    = !mode;
          cmd.map_wr  = mode;
          cmd.idx_clr = 1'b1;
        end
      end
      ST_MOD: begin
        cmd.src = SRC_MOD;
        if (stat.adv_ok) begin
          cmd.step    = 1'b1;
          cmd.idx_clr = stat.mod_last;
          cmd.idx_inc = !stat.mod_last;
        end
      end
      ST_KEY_RD: begin
        cmd.src     = SRC_KEY;
        cmd.rd_key  = !stat.key_end;
        cmd.idx_clr = stat.key_end;
      end
      ST_KEY_CHK: begin
        cmd.src = SRC_KEY;
        if (stat.adv_ok) begin
          cmd.step    = 1'b1;
          cmd.idx_inc = 1'b1;
        end
      end
      ST_REL_RD: begin
        cmd.src    = SRC_REL;
        cmd.rd_rel = !stat.rel_end;
      end
      ST_REL_CHK: begin
        cmd.src = SRC_REL;
        if (stat.adv_ok) begin
          cmd.step    = 1'b1;
          cmd.idx_inc = 1'b1;
        end
      end
      ST_FIN: begin
        cmd.finish = stat.fin_ok;
      end
      default: cmd = '0;
    endcase
  end

endmodule

>>> rtl/kbr_dpath.sv
module kbr_dpath
  import kbr_pkg::*;
#(
  parameter int KEY_SLOTS   = KEY_SLOTS_DEF,
  parameter int MAP_ENTRIES = MAP_ENTRIES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  ctl_cmd_t          cmd,
  output ctl_stat_t         stat,
  input  logic [KEY_W-1:0]  modifier_bits,
  input  logic [KEY_W-1:0]  key_slot_0,
  input  logic [KEY_W-1:0]  key_slot_1,
  input  logic [KEY_W-1:0]  key_slot_2,
  input  logic [KEY_W-1:0]  key_slot_3,
  input  logic [KEY_W-1:0]  key_slot_4,
  input  logic [KEY_W-1:0]  key_slot_5,
  input  logic [MIDX_W-1:0] map_index,
  input  logic [CODE_W-1:0] map_value,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [CODE_W-1:0] scan_code,
  output logic              released,
  output logic              last_event
);

  localparam int USED_SLOTS = (KEY_SLOTS < INPUT_SLOTS) ? KEY_SLOTS : INPUT_SLOTS;
  localparam int AW         = $clog2(MAP_ENTRIES);

  // History and working copies.
  logic [MOD_KEYS-1:0] prev_mods;
  logic [MOD_KEYS-1:0] was_mods;
  logic [KEY_W-1:0]    prev_keys [INPUT_SLOTS];
  logic [IDX_W-1:0]    prev_count;
  logic [KEY_W-1:0]    old_keys [INPUT_SLOTS];
  logic [IDX_W-1:0]    old_count;
  logic [IDX_W-1:0]    idx;

  // Translation maps.
  logic [CODE_W-1:0]      mod_map [MOD_KEYS];
  logic [MAP_ENTRIES-1:0] map_vld;
  logic                   vld_q;
  logic [CODE_W-1:0]      ram_q;

  // Event held back until the next one shows whether it is the last.
  logic              pend_valid;
  logic [CODE_W-1:0] pend_code;
  logic              pend_rel;

  logic [KEY_W-1:0]  slot_in [INPUT_SLOTS];
  logic [IDX_W-1:0]  cur_count;
  logic              cnt_done;
  logic [KEY_W-1:0]  cur_key;
  logic              mfound;
  logic [IDX_W-1:0]  midx;
  logic              hit;
  logic              here;
  logic [CODE_W-1:0] ev_code;
  logic              ev_rel;
  logic              emit_ok;
  logic              key_wr;
  logic              mod_wr;
  logic [MIDX_W-1:0] mod_off;
  logic              ram_re;
  logic [AW-1:0]     ram_raddr;

  assign slot_in[0] = key_slot_0;
  assign slot_in[1] = key_slot_1;
  assign slot_in[2] = key_slot_2;
  assign slot_in[3] = key_slot_3;
  assign slot_in[4] = key_slot_4;
  assign slot_in[5] = key_slot_5;

  // Number of keys in the report: slots before the first empty one.
  always_comb begin
    cur_count = '0;
    cnt_done  = 1'b0;
    for (int i = 0; i < USED_SLOTS; i++) begin
      if (!cnt_done) begin
        if (slot_in[i] == '0) begin
          cnt_done = 1'b1;
        end else begin
          cur_count = cur_count + IDX_W'(1);
        end
      end
    end
  end

  // Map write decode. Key entry zero is never written.
  assign mod_off = map_index - MIDX_W'(MAP_ENTRIES);
  assign key_wr  = cmd.map_wr && (map_index < MIDX_W'(MAP_ENTRIES)) && (map_index != '0);
  assign mod_wr  = cmd.map_wr && (map_index >= MIDX_W'(MAP_ENTRIES))
                   && (mod_off < MIDX_W'(MOD_KEYS));

  // Key map lookup address: a new key or a remaining previous key.
  assign cur_key   = prev_keys[idx];
  assign ram_re    = cmd.rd_key || cmd.rd_rel;
  assign ram_raddr = cmd.rd_rel ? AW'(old_keys[idx]) : AW'(cur_key);

  kbr_ram #(
    .WIDTH (CODE_W),
    .DEPTH (MAP_ENTRIES)
  ) u_key_map (
    .clk   (clk),
    .we    (key_wr),
    .waddr (map_index[AW-1:0]),
    .wdata (map_value),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_q)
  );

  assign hit = vld_q && (ram_q != '0);

  // First unconsumed previous key with the same code.
  always_comb begin
    mfound = 1'b0;
    midx   = '0;
    for (int j = 0; j < INPUT_SLOTS; j++) begin
      if (!mfound && (IDX_W'(j) < old_count) && (old_keys[j] == cur_key)) begin
        mfound = 1'b1;
        midx   = IDX_W'(j);
      end
    end
  end

  // Event under test for the current phase.
  always_comb begin
    unique case (cmd.src)
      SRC_MOD: begin
        here    = was_mods[idx] ^ prev_mods[idx];
        ev_code = mod_map[idx];
        ev_rel  = was_mods[idx];
      end
      SRC_KEY: begin
        here    = !mfound && hit;
        ev_code = ram_q;
        ev_rel  = 1'b0;
      end
      SRC_REL: begin
        here    = hit;
        ev_code = ram_q;
        ev_rel  = 1'b1;
      end
      default: begin
        here    = 1'b0;
        ev_code = '0;
        ev_rel  = 1'b0;
      end
    endcase
  end

  // Status for the controller.
  assign emit_ok       = !out_valid || !out_stall;
  assign stat.mod_last = (idx == IDX_W'(MOD_KEYS - 1));
  assign stat.key_end  = (idx >= prev_count);
  assign stat.rel_end  = (idx >= old_count);
  assign stat.adv_ok   = !here || !pend_valid || emit_ok;
  assign stat.fin_ok   = !pend_valid || emit_ok;

  // Index counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (cmd.idx_clr) begin
      idx <= '0;
    end else if (cmd.idx_inc) begin
      idx <= idx + IDX_W'(1);
    end
  end

  // History update when a report is taken; the old state is copied for the compare.
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_mods  <= '0;
      prev_count <= '0;
      for (int j = 0; j < INPUT_SLOTS; j++) begin
        prev_keys[j] <= '0;
      end
    end else if (cmd.load) begin
      prev_mods  <= modifier_bits;
      prev_count <= cur_count;
      for (int j = 0; j < INPUT_SLOTS; j++) begin
        prev_keys[j] <= (IDX_W'(j) < cur_count) ? slot_in[j] : '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      was_mods  <= prev_mods;
      old_count <= prev_count;
      for (int j = 0; j < INPUT_SLOTS; j++) begin
        old_keys[j] <= prev_keys[j];
      end
    end else if (cmd.step && (cmd.src == SRC_KEY) && mfound) begin
      old_keys[midx] <= '0;
    end
  end

  // Modifier map and key map valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      map_vld <= '0;
      for (int i = 0; i < MOD_KEYS; i++) begin
        mod_map[i] <= '0;
      end
    end else begin
      if (key_wr) begin
        map_vld[map_index[AW-1:0]] <= 1'b1;
      end
      if (mod_wr) begin
        mod_map[mod_off[IDX_W-1:0]] <= map_value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_q <= 1'b0;
    end else if (ram_re) begin
      vld_q <= map_vld[ram_raddr];
    end
  end

  // Pending event and output word register.
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.step && here) begin
        pend_valid <= 1'b1;
        pend_code  <= ev_code;
        pend_rel   <= ev_rel;
        if (pend_valid) begin
          out_valid  <= 1'b1;
          scan_code  <= pend_code;
          released   <= pend_rel;
          last_event <= 1'b0;
        end else if (!out_stall) begin
          out_valid <= 1'b0;
        end
      end else if (cmd.finish && pend_valid) begin
        pend_valid <= 1'b0;
        out_valid  <= 1'b1;
        scan_code  <= pend_code;
        released   <= pend_rel;
        last_event <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

>>> rtl/keyboard_report_to_key_events.sv
// A report keeps the block busy after it is taken, through 8 modifier steps,
// a read and a check step per key in the report and per previous key (one key map
// RAM read each), an end step for each key list and a finish step.
// A new report is taken only when the last one is finished, output stalls included; a map write is taken in idle.
// Reset clears key history, the modifier map and the key map valid bits,
// so every key reads as ignored until its map entry is written.
module keyboard_report_to_key_events
  import kbr_pkg::*;
#(
  parameter int KEY_SLOTS   = KEY_SLOTS_DEF,
  parameter int MAP_ENTRIES = MAP_ENTRIES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              mode,
  input  logic [KEY_W-1:0]  modifier_bits,
  input  logic [KEY_W-1:0]  key_slot_0,
  input  logic [KEY_W-1:0]  key_slot_1,
  input  logic [KEY_W-1:0]  key_slot_2,
  input  logic [KEY_W-1:0]  key_slot_3,
  input  logic [KEY_W-1:0]  key_slot_4,
  input  logic [KEY_W-1:0]  key_slot_5,
  input  logic [MIDX_W-1:0] map_index,
  input  logic [CODE_W-1:0] map_value,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [CODE_W-1:0] scan_code,
  output logic              released,
  output logic              last_event
);

  ctl_cmd_t  cmd;
  ctl_stat_t stat;

  // Sequencer.
  kbr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .mode     (mode),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // History, maps and output word register.
  kbr_dpath #(
    .KEY_SLOTS   (KEY_SLOTS),
    .MAP_ENTRIES (MAP_ENTRIES)
  ) u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .modifier_bits (modifier_bits),
    .key_slot_0    (key_slot_0),
    .key_slot_1    (key_slot_1),
    .key_slot_2    (key_slot_2),
    .key_slot_3    (key_slot_3),
    .key_slot_4    (key_slot_4),
    .key_slot_5    (key_slot_5),
    .map_index     (map_index),
    .map_value     (map_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .scan_code     (scan_code),
    .released      (released),
    .last_event    (last_event)
  );

endmodule

>>> dv/tb_keyboard_report_to_key_events.sv
module tb_keyboard_report_to_key_events;
  timeunit 1ns;
  timeprecision 1ps;

  import kbr_pkg::*;

  // Word kinds on the input channel.
  localparam logic MODE_REPORT    = 1'b0;
  localparam logic MODE_MAP_WRITE = 1'b1;

  // First map index that addresses the modifier map.
  localparam int MOD_MAP_BASE  = 256;
  localparam int KEY_POOL_SIZE = 12;
  localparam int RANDOM_WORDS  = 110;
  localparam int DRAIN_CYCLES  = 40;
  localparam int CYCLE_LIMIT   = 400000;

  // Receiver stall styles.
  typedef enum int {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_style_t;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic              rel;
    logic              last;
  } key_event_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic              mode = MODE_REPORT;
  logic [KEY_W-1:0]  modifier_bits = '0;
  logic [KEY_W-1:0]  key_slot_0 = '0;
  logic [KEY_W-1:0]  key_slot_1 = '0;
  logic [KEY_W-1:0]  key_slot_2 = '0;
  logic [KEY_W-1:0]  key_slot_3 = '0;
  logic [KEY_W-1:0]  key_slot_4 = '0;
  logic [KEY_W-1:0]  key_slot_5 = '0;
  logic [MIDX_W-1:0] map_index = '0;
  logic [CODE_W-1:0] map_value = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [CODE_W-1:0] scan_code;
  logic              released;
  logic              last_event;

  // Shadow copy of the block's history and translation tables.
  logic [KEY_W-1:0]  shadow_mods;
  logic [KEY_W-1:0]  shadow_keys [INPUT_SLOTS];
  int                shadow_key_count;
  logic [CODE_W-1:0] shadow_key_map [256];
  logic [CODE_W-1:0] shadow_mod_map [MOD_KEYS];

  key_event_t        expected_key_events [$];
  logic [KEY_W-1:0]  key_pool [KEY_POOL_SIZE];

  int errors = 0;
  int reports_sent = 0;
  int map_writes_sent = 0;
  int events_checked = 0;
  int cycle_count = 0;
  int burst_left = 1;
  bit steady_sender = 1'b0;
  bit valid_on = 1'b0;

  keyboard_report_to_key_events i_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .mode          (mode),
    .modifier_bits (modifier_bits),
    .key_slot_0    (key_slot_0),
    .key_slot_1    (key_slot_1),
    .key_slot_2    (key_slot_2),
    .key_slot_3    (key_slot_3),
    .key_slot_4    (key_slot_4),
    .key_slot_5    (key_slot_5),
    .map_index     (map_index),
    .map_value     (map_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .scan_code     (scan_code),
    .released      (released),
    .last_event    (last_event)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Abort the run if it hangs.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d key events still expected", $time,
               expected_key_events.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  // The receiver switches between stall styles during the run.
  always @(posedge clk) begin
    stall_style_t style;
    if (cycle_count % 97 == 0) begin
      style = stall_style_t'($urandom_range(0, 3));
    end
    case (style)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: out_stall <= ($urandom_range(0, 9) < 7);
      default:     out_stall <= ((cycle_count % 5) < 2);
    endcase
  end

  // Compare every accepted event word with the oldest expectation.
  always @(posedge clk) begin
    key_event_t want;
    if (!rst && out_valid && !out_stall) begin
      events_checked++;
      if (expected_key_events.size() == 0) begin
        errors++;
        $display("%0t: unexpected event word scan_code=%h released=%b last_event=%b",
                 $time, scan_code, released, last_event);
      end else begin
        want = expected_key_events.pop_front();
        if (scan_code !== want.code) begin
          errors++;
          $display("%0t: scan_code expected %h actual %h", $time, want.code, scan_code);
        end
        if (released !== want.rel) begin
          errors++;
          $display("%0t: released expected %b actual %b", $time, want.rel, released);
        end
        if (last_event !== want.last) begin
          errors++;
          $display("%0t: last_event expected %b actual %b", $time, want.last, last_event);
        end
      end
    end
  end

  function automatic logic [INPUT_SLOTS-1:0][KEY_W-1:0] make_slots(
    input logic [KEY_W-1:0] k0, input logic [KEY_W-1:0] k1, input logic [KEY_W-1:0] k2,
    input logic [KEY_W-1:0] k3, input logic [KEY_W-1:0] k4, input logic [KEY_W-1:0] k5);
    logic [INPUT_SLOTS-1:0][KEY_W-1:0] s;
    s[0] = k0;
    s[1] = k1;
    s[2] = k2;
    s[3] = k3;
    s[4] = k4;
    s[5] = k5;
    return s;
  endfunction

  function automatic logic [CODE_W-1:0] key_scan_code(input logic [KEY_W-1:0] code);
    if (code == '0) begin
      return '0;
    end
    return shadow_key_map[code];
  endfunction

  task automatic clear_shadow();
    shadow_mods = '0;
    shadow_key_count = 0;
    foreach (shadow_keys[i]) shadow_keys[i] = '0;
    foreach (shadow_key_map[i]) shadow_key_map[i] = '0;
    foreach (shadow_mod_map[i]) shadow_mod_map[i] = '0;
  endtask

  // A map write touches only the tables; index 0 and indexes past the
  // modifier map are dropped.
  task automatic apply_map_write(input logic [MIDX_W-1:0] idx, input logic [CODE_W-1:0] val);
    if (idx < MOD_MAP_BASE) begin
      if (idx != 0) begin
        shadow_key_map[idx[KEY_W-1:0]] = val;
      end
    end else if (idx < MOD_MAP_BASE + MOD_KEYS) begin
      shadow_mod_map[idx - MOD_MAP_BASE] = val;
    end
  endtask

  // Turn one report into make and break events against the stored history.
  task automatic translate_report(input logic [KEY_W-1:0] mods,
                                  input logic [INPUT_SLOTS-1:0][KEY_W-1:0] slots);
    logic [KEY_W-1:0] unmatched [INPUT_SLOTS];
    logic [KEY_W-1:0] now_keys [INPUT_SLOTS];
    int now_count;
    int produced;
    bit hit;
    produced = 0;
    now_count = 0;

    // Modifier edges, bit 0 first, regardless of the map entry.
    for (int i = 0; i < MOD_KEYS; i++) begin
      if (mods[i] != shadow_mods[i]) begin
        expected_key_events.push_back('{shadow_mod_map[i], shadow_mods[i], 1'b0});
        produced++;
      end
    end
    shadow_mods = mods;

    foreach (unmatched[j]) unmatched[j] = shadow_keys[j];
    foreach (now_keys[j]) now_keys[j] = '0;

    // New keys in slot order; each consumes the first equal previous key.
    for (int i = 0; i < INPUT_SLOTS; i++) begin
      if (slots[i] == '0) break;
      now_keys[now_count] = slots[i];
      now_count++;
      hit = 1'b0;
      for (int j = 0; j < shadow_key_count; j++) begin
        if (!hit && unmatched[j] == slots[i]) begin
          unmatched[j] = '0;
          hit = 1'b1;
        end
      end
      if (!hit && key_scan_code(slots[i]) != '0) begin
        expected_key_events.push_back('{key_scan_code(slots[i]), 1'b0, 1'b0});
        produced++;
      end
    end

    // Previous keys left over are released in stored order.
    for (int j = 0; j < shadow_key_count; j++) begin
      if (key_scan_code(unmatched[j]) != '0) begin
        expected_key_events.push_back('{key_scan_code(unmatched[j]), 1'b1, 1'b0});
        produced++;
      end
    end

    foreach (shadow_keys[j]) shadow_keys[j] = now_keys[j];
    shadow_key_count = now_count;
    if (produced > 0) begin
      expected_key_events[$].last = 1'b1;
    end
  endtask

  // Present one word, wait for it to be taken, then maybe open a gap.
  task automatic send_word(input logic m, input logic [KEY_W-1:0] mods,
                           input logic [INPUT_SLOTS-1:0][KEY_W-1:0] slots,
                           input logic [MIDX_W-1:0] idx, input logic [CODE_W-1:0] val);
    int gap;
    mode <= m;
    modifier_bits <= mods;
    key_slot_0 <= slots[0];
    key_slot_1 <= slots[1];
    key_slot_2 <= slots[2];
    key_slot_3 <= slots[3];
    key_slot_4 <= slots[4];
    key_slot_5 <= slots[5];
    map_index <= idx;
    map_value <= val;
    in_valid <= 1'b1;
    valid_on = 1'b1;
    do @(posedge clk); while (in_stall);

    if (m == MODE_MAP_WRITE) begin
      apply_map_write(idx, val);
      map_writes_sent++;
    end else begin
      translate_report(mods, slots);
      reports_sent++;
    end

    burst_left--;
    if (!steady_sender && burst_left <= 0) begin
      burst_left = $urandom_range(1, 8);
      gap = $urandom_range(0, 10);
      if (gap > 0) begin
        in_valid <= 1'b0;
        valid_on = 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Reports carry random junk in the map fields, and map writes in the report fields.
  task automatic send_report(input logic [KEY_W-1:0] mods,
                             input logic [INPUT_SLOTS-1:0][KEY_W-1:0] slots);
    send_word(MODE_REPORT, mods, slots, MIDX_W'($urandom), CODE_W'($urandom));
  endtask

  task automatic send_map_write(input logic [MIDX_W-1:0] idx, input logic [CODE_W-1:0] val);
    send_word(MODE_MAP_WRITE, KEY_W'($urandom),
              make_slots(KEY_W'($urandom), KEY_W'($urandom), KEY_W'($urandom),
                         KEY_W'($urandom), KEY_W'($urandom), KEY_W'($urandom)),
              idx, val);
  endtask

  // Modifier edges before and after the modifier map is loaded; unloaded
  // entries still give events with a zero scan code.
  task automatic test_modifier_edges();
    send_report(8'hFF, '0);
    send_map_write(MIDX_W'(MOD_MAP_BASE + 0), 16'h0001);
    send_map_write(MIDX_W'(MOD_MAP_BASE + 3), 16'h1E03);
    send_map_write(MIDX_W'(MOD_MAP_BASE + 6), 16'hE006);
    send_map_write(MIDX_W'(MOD_MAP_BASE + 7), 16'hFFFF);
    send_report(8'h00, '0);
  endtask

  // Key map loading, including the ignored entry 0 and an out-of-range index.
  task automatic test_map_loading();
    logic [KEY_W-1:0] codes [12];
    codes = '{8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09,
              8'h0A, 8'h0B, 8'h0C, 8'h0D, 8'h80, 8'hFF};
    send_map_write(9'd0, 16'h1234);
    send_map_write(9'd511, 16'hFFFF);
    foreach (codes[i]) begin
      send_map_write({1'b0, codes[i]}, (codes[i] == 8'hFF) ? 16'hFFFF : {8'h01, codes[i]});
    end
  endtask

  // Presses, a full twenty-event swap, an unchanged report, duplicates,
  // an early zero slot, unmapped keys, and a full release.
  task automatic test_key_changes();
    send_report(8'hA5, make_slots(8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09));
    send_report(8'h5A, make_slots(8'h0A, 8'h0B, 8'h0C, 8'h0D, 8'h80, 8'hFF));
    send_report(8'h5A, make_slots(8'h0A, 8'h0B, 8'h0C, 8'h0D, 8'h80, 8'hFF));
    send_report(8'h5A, make_slots(8'hFF, 8'h0A, 8'h0A, 8'h20, 8'h00, 8'h0B));
    send_report(8'h00, '0);
  endtask

  // Unmapping a held key silences its later release.
  task automatic test_unmap_held_key();
    send_report(8'h00, make_slots(8'h04, 8'h05, 8'h00, 8'h00, 8'h00, 8'h00));
    send_map_write(9'h004, 16'h0000);
    send_report(8'h00, make_slots(8'h05, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    send_report(8'h00, '0);
  endtask

  // Mostly reports that evolve from the held keys, with junk reports and
  // map rewrites mixed in.
  task automatic test_random_traffic();
    logic [INPUT_SLOTS-1:0][KEY_W-1:0] slots;
    logic [KEY_W-1:0] mods;
    logic [KEY_W-1:0] tmp;
    logic [MIDX_W-1:0] idx;
    int pick;
    int n;

    key_pool[0] = 8'hFF;
    key_pool[1] = 8'h01;
    key_pool[2] = 8'h80;
    for (int i = 3; i < KEY_POOL_SIZE; i++) key_pool[i] = KEY_W'($urandom_range(1, 255));
    steady_sender = 1'b1;
    for (int i = 0; i < KEY_POOL_SIZE; i++) begin
      send_map_write({1'b0, key_pool[i]}, CODE_W'($urandom_range(1, 65535)));
    end

    for (int w = 0; w < RANDOM_WORDS; w++) begin
      if (w == 40) steady_sender = 1'b0;
      pick = $urandom_range(0, 99);
      slots = '0;
      if (pick < 12) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: idx = {1'b0, key_pool[$urandom_range(0, KEY_POOL_SIZE - 1)]};
          6, 7:             idx = MIDX_W'(MOD_MAP_BASE + $urandom_range(0, MOD_KEYS - 1));
          default:          idx = MIDX_W'($urandom);
        endcase
        send_map_write(idx, ($urandom_range(0, 9) == 0) ? '0 : CODE_W'($urandom));
      end else if (pick < 25) begin
        mods = KEY_W'($urandom);
        for (int k = 0; k < INPUT_SLOTS; k++) begin
          slots[k] = ($urandom_range(0, 3) == 0) ? '0 : KEY_W'($urandom);
        end
        send_report(mods, slots);
      end else begin
        mods = shadow_mods ^ (($urandom_range(0, 2) == 0) ? KEY_W'($urandom) : '0);
        n = 0;
        for (int k = 0; k < shadow_key_count; k++) begin
          if ($urandom_range(0, 3) != 0) begin
            slots[n] = shadow_keys[k];
            n++;
          end
        end
        while (n < INPUT_SLOTS && $urandom_range(0, 2) != 0) begin
          slots[n] = key_pool[$urandom_range(0, KEY_POOL_SIZE - 1)];
          n++;
        end
        if (n > 1 && $urandom_range(0, 3) == 0) begin
          tmp = slots[0];
          slots[0] = slots[n - 1];
          slots[n - 1] = tmp;
        end
        if ($urandom_range(0, 9) == 0) begin
          slots[$urandom_range(0, INPUT_SLOTS - 1)] = KEY_W'($urandom);
        end
        send_report(mods, slots);
      end
    end
  endtask

  // Let every expected event drain, then give the block time to misbehave.
  task automatic drain_events();
    if (valid_on) in_valid <= 1'b0;
    valid_on = 1'b0;
    while (expected_key_events.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    clear_shadow();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_modifier_edges();
    test_map_loading();
    test_key_changes();
    test_unmap_held_key();
    test_random_traffic();
    drain_events();

    $display("Run covered %0d reports and %0d map writes, %0d event words checked.",
             reports_sent, map_writes_sent, events_checked);
    $display("Mismatches found: %0d.", errors);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/kbr_pkg.sv
rtl/kbr_ram.sv
rtl/kbr_ctrl.sv
rtl/kbr_dpath.sv
rtl/keyboard_report_to_key_events.sv
dv/tb_keyboard_report_to_key_events.sv
